// ===== hw/rtl/dfs_pkg.sv =====
package dfs_pkg;

  localparam logic OP_BEGIN = 1'b0;
  localparam logic OP_CAND  = 1'b1;

  localparam int         WEIGHT_BITS  = 8;
  localparam logic [7:0] WEIGHT_RESET = 8'd16;
  localparam int         FWD_SHIFT    = 4;

  localparam int OQ_DEPTH    = 8;
  localparam int OQ_PTR_BITS = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_BITS = $clog2(OQ_DEPTH + 1);

  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_RIGHT = 2'd3
  } dir_t;

  typedef enum logic [1:0] {
    SRC_NONE        = 2'd0,
    SRC_OVERRIDE    = 2'd1,
    SRC_DIRECTIONAL = 2'd2,
    SRC_WRAPPED     = 2'd3
  } src_t;

  // per-query flags that travel with every item of the query
  typedef struct packed {
    logic origin_nz;
    logic ovr_valid;
    logic wrap;
  } qflags_t;

  typedef struct packed {
    logic    valid;
    logic    is_begin;
    logic    emit;
    logic    cand_ok;
    logic    ahead;
    qflags_t q;
  } stg_ctl_t;

endpackage

// ===== hw/rtl/dfs_geom.sv =====
module dfs_geom #(
  parameter int C = 20,
  parameter int I = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  logic                in_opcode,
  input  logic [I-1:0]        in_node_id,
  input  logic signed [C-1:0] in_rect_x,
  input  logic signed [C-1:0] in_rect_y,
  input  logic [C-2:0]        in_rect_w,
  input  logic [C-2:0]        in_rect_h,
  input  dfs_pkg::dir_t       in_direction,
  input  logic                in_wrap,
  input  logic [I-1:0]        in_ovr_id,
  input  logic                in_ovr_ok,
  input  logic                in_last,
  output logic                a_valid,
  output dfs_pkg::stg_ctl_t   b_ctl_r,
  output logic [I-1:0]        b_id_r,
  output logic [I-1:0]        b_ovr_id_r,
  output logic [C-1:0]        b_fwd_r,
  output logic [C-1:0]        b_gap_r,
  output logic signed [C+1:0] b_lo_r,
  output logic [C+1:0]        b_ux_r,
  output logic [C+1:0]        b_uy_r
);
  import dfs_pkg::*;

  localparam int SW = C + 2;
  localparam int AW = C + 3;
  localparam int PW = C + 4;

  // input stage
  logic                a_v_r;
  logic                a_op_r;
  logic [I-1:0]        a_id_r;
  logic signed [C-1:0] a_x_r;
  logic signed [C-1:0] a_y_r;
  logic [C-2:0]        a_w_r;
  logic [C-2:0]        a_h_r;
  dir_t                a_dir_r;
  logic                a_wrap_r;
  logic [I-1:0]        a_ovr_id_r;
  logic                a_ovr_ok_r;
  logic                a_last_r;

  // open query
  logic                open_r;
  logic [I-1:0]        o_key_r;
  logic signed [C-1:0] o_x_r;
  logic signed [C-1:0] o_y_r;
  logic [C-2:0]        o_w_r;
  logic [C-2:0]        o_h_r;
  dir_t                o_dir_r;
  qflags_t             o_flags_r;
  logic [I-1:0]        o_ovr_id_r;

  logic signed [SW-1:0] cx, cy, cw, ch, cxe, cye;
  logic signed [SW-1:0] ox, oy, ow, oh, oxe, oye;
  logic signed [SW-1:0] ca_lo, ca_hi, oa_lo, oa_hi, cs_lo, cs_hi, os_lo, os_hi;
  logic signed [AW-1:0] csum, osum, fwd_d, gap1, gap2, gap_m;
  logic signed [PW-1:0] pcx, pcy, pox, poy, dx, dy, ndx, ndy;
  logic                 is_begin;
  qflags_t              a_flags;
  stg_ctl_t             b_ctl_nxt;

  assign a_valid  = a_v_r;
  assign is_begin = (a_op_r == OP_BEGIN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else begin
      a_v_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_op_r     <= in_opcode;
      a_id_r     <= in_node_id;
      a_x_r      <= in_rect_x;
      a_y_r      <= in_rect_y;
      a_w_r      <= in_rect_w;
      a_h_r      <= in_rect_h;
      a_dir_r    <= in_direction;
      a_wrap_r   <= in_wrap;
      a_ovr_id_r <= in_ovr_id;
      a_ovr_ok_r <= in_ovr_ok;
      a_last_r   <= in_last;
    end
  end

  assign a_flags.origin_nz = (a_id_r != '0);
  assign a_flags.ovr_valid = a_ovr_ok_r && (a_ovr_id_r != '0);
  assign a_flags.wrap      = a_wrap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r  <= 1'b0;
      o_key_r <= '0;
    end else if (a_v_r && is_begin) begin
      open_r  <= !a_last_r;
      o_key_r <= a_id_r;
    end else if (a_v_r && a_last_r) begin
      open_r  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_v_r && is_begin) begin
      o_x_r      <= a_x_r;
      o_y_r      <= a_y_r;
      o_w_r      <= a_w_r;
      o_h_r      <= a_h_r;
      o_dir_r    <= a_dir_r;
      o_flags_r  <= a_flags;
      o_ovr_id_r <= a_ovr_id_r;
    end
  end

  assign cx  = SW'(a_x_r);
  assign cy  = SW'(a_y_r);
  assign cw  = SW'(a_w_r);
  assign ch  = SW'(a_h_r);
  assign cxe = cx + cw;
  assign cye = cy + ch;
  assign ox  = SW'(o_x_r);
  assign oy  = SW'(o_y_r);
  assign ow  = SW'(o_w_r);
  assign oh  = SW'(o_h_r);
  assign oxe = ox + ow;
  assign oye = oy + oh;

  // spans along the travel axis, flipped so that ahead is larger
  always_comb begin
    unique case (o_dir_r)
      DIR_UP: begin
        ca_lo = -cye; ca_hi = -cy; oa_lo = -oye; oa_hi = -oy;
        cs_lo = cx;   cs_hi = cxe; os_lo = ox;   os_hi = oxe;
      end
      DIR_DOWN: begin
        ca_lo = cy;   ca_hi = cye; oa_lo = oy;   oa_hi = oye;
        cs_lo = cx;   cs_hi = cxe; os_lo = ox;   os_hi = oxe;
      end
      DIR_LEFT: begin
        ca_lo = -cxe; ca_hi = -cx; oa_lo = -oxe; oa_hi = -ox;
        cs_lo = cy;   cs_hi = cye; os_lo = oy;   os_hi = oye;
      end
      default: begin
        ca_lo = cx;   ca_hi = cxe; oa_lo = ox;   oa_hi = oxe;
        cs_lo = cy;   cs_hi = cye; os_lo = oy;   os_hi = oye;
      end
    endcase
  end

  assign csum  = AW'(ca_lo) + AW'(ca_hi);
  assign osum  = AW'(oa_lo) + AW'(oa_hi);
  assign fwd_d = AW'(ca_lo) - AW'(oa_hi);
  assign gap1  = AW'(cs_lo) - AW'(os_hi);
  assign gap2  = AW'(os_lo) - AW'(cs_hi);
  assign gap_m = (gap1 > gap2) ? gap1 : gap2;

  // doubled centres
  assign pcx = (PW'(cx) <<< 1) + PW'(cw);
  assign pcy = (PW'(cy) <<< 1) + PW'(ch);
  assign pox = (PW'(ox) <<< 1) + PW'(ow);
  assign poy = (PW'(oy) <<< 1) + PW'(oh);
  assign dx  = pcx - pox;
  assign dy  = pcy - poy;
  assign ndx = -dx;
  assign ndy = -dy;

  always_comb begin
    b_ctl_nxt.valid    = a_v_r;
    b_ctl_nxt.is_begin = is_begin;
    b_ctl_nxt.emit     = a_last_r && (is_begin || open_r);
    b_ctl_nxt.cand_ok  = !is_begin && open_r && (a_id_r != '0) && (a_id_r != o_key_r);
    b_ctl_nxt.ahead    = (csum > osum);
    b_ctl_nxt.q        = is_begin ? a_flags : o_flags_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_ctl_r <= '0;
    end else begin
      b_ctl_r <= b_ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b_id_r     <= a_id_r;
    b_ovr_id_r <= is_begin ? a_ovr_id_r : o_ovr_id_r;
    b_fwd_r    <= fwd_d[AW-1] ? '0 : fwd_d[C-1:0];
    b_gap_r    <= gap_m[AW-1] ? '0 : gap_m[C-1:0];
    b_lo_r     <= ca_lo;
    b_ux_r     <= dx[PW-1] ? ndx[C+1:0] : dx[C+1:0];
    b_uy_r     <= dy[PW-1] ? ndy[C+1:0] : dy[C+1:0];
  end

endmodule

// ===== hw/rtl/dfs_score.sv =====
module dfs_score #(
  parameter int C = 20,
  parameter int I = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [7:0]                 weight,
  input  dfs_pkg::stg_ctl_t          b_ctl_r,
  input  logic [I-1:0]               b_id_r,
  input  logic [I-1:0]               b_ovr_id_r,
  input  logic [C-1:0]               b_fwd_r,
  input  logic [C-1:0]               b_gap_r,
  input  logic signed [C+1:0]        b_lo_r,
  input  logic [C+1:0]               b_ux_r,
  input  logic [C+1:0]               b_uy_r,
  output dfs_pkg::stg_ctl_t          c_ctl_r,
  output logic [I-1:0]               c_id_r,
  output logic [I-1:0]               c_ovr_id_r,
  output logic signed [C+9:0]        c_sc_r,
  output logic signed [C+9:0]        c_ws_r,
  output logic [2*C+4:0]             c_dist_r
);
  import dfs_pkg::*;

  localparam int SCW = C + 10;
  localparam int DW  = 2 * C + 5;
  localparam int SDW = C + WEIGHT_BITS;

  logic [SDW-1:0]        side;
  logic [2*C+3:0]        sqx, sqy;
  logic signed [SCW-1:0] sc, ws;

  assign side = SDW'(weight) * SDW'(b_gap_r);
  assign sqx  = b_ux_r * b_ux_r;
  assign sqy  = b_uy_r * b_uy_r;
  assign sc   = (SCW'(b_fwd_r) << FWD_SHIFT) + SCW'(side);
  assign ws   = (SCW'(b_lo_r) <<< FWD_SHIFT) + SCW'(side);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_ctl_r <= '0;
    end else begin
      c_ctl_r <= b_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    c_id_r     <= b_id_r;
    c_ovr_id_r <= b_ovr_id_r;
    c_sc_r     <= sc;
    c_ws_r     <= ws;
    c_dist_r   <= DW'(sqx) + DW'(sqy);
  end

endmodule

// ===== hw/rtl/dfs_best.sv =====
module dfs_best #(
  parameter int C = 20,
  parameter int I = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dfs_pkg::stg_ctl_t   c_ctl_r,
  input  logic [I-1:0]        c_id_r,
  input  logic [I-1:0]        c_ovr_id_r,
  input  logic signed [C+9:0] c_sc_r,
  input  logic signed [C+9:0] c_ws_r,
  input  logic [2*C+4:0]      c_dist_r,
  output logic                push,
  output logic                push_found,
  output logic [I-1:0]        push_id,
  output dfs_pkg::src_t       push_src
);
  import dfs_pkg::*;

  localparam int SCW = C + 10;
  localparam int DW  = 2 * C + 5;

  logic [I-1:0]          ah_id_r, ah_id_nxt, wr_id_r, wr_id_nxt;
  logic signed [SCW-1:0] ah_sc_r, ah_sc_nxt, wr_sc_r, wr_sc_nxt;
  logic [DW-1:0]         ah_dist_r, ah_dist_nxt, wr_dist_r, wr_dist_nxt;
  logic                  ah_take, wr_take;

  // an empty best (id zero) is beaten by any candidate
  assign ah_take = c_ctl_r.cand_ok && c_ctl_r.ahead &&
                   ((ah_id_r == '0) || (c_sc_r < ah_sc_r) ||
                    ((c_sc_r == ah_sc_r) && (c_dist_r < ah_dist_r)));
  assign wr_take = c_ctl_r.cand_ok &&
                   ((wr_id_r == '0) || (c_ws_r < wr_sc_r) ||
                    ((c_ws_r == wr_sc_r) && (c_dist_r < wr_dist_r)));

  always_comb begin
    ah_id_nxt   = ah_id_r;
    ah_sc_nxt   = ah_sc_r;
    ah_dist_nxt = ah_dist_r;
    wr_id_nxt   = wr_id_r;
    wr_sc_nxt   = wr_sc_r;
    wr_dist_nxt = wr_dist_r;
    if (c_ctl_r.valid && c_ctl_r.is_begin) begin
      ah_id_nxt = '0;
      wr_id_nxt = '0;
    end else if (c_ctl_r.valid) begin
      if (ah_take) begin
        ah_id_nxt   = c_id_r;
        ah_sc_nxt   = c_sc_r;
        ah_dist_nxt = c_dist_r;
      end
      if (wr_take) begin
        wr_id_nxt   = c_id_r;
        wr_sc_nxt   = c_ws_r;
        wr_dist_nxt = c_dist_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ah_id_r <= '0;
      wr_id_r <= '0;
    end else begin
      ah_id_r <= ah_id_nxt;
      wr_id_r <= wr_id_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ah_sc_r   <= ah_sc_nxt;
    ah_dist_r <= ah_dist_nxt;
    wr_sc_r   <= wr_sc_nxt;
    wr_dist_r <= wr_dist_nxt;
  end

  assign push = c_ctl_r.valid && c_ctl_r.emit;

  always_comb begin
    push_found = 1'b1;
    push_id    = '0;
    push_src   = SRC_NONE;
    priority if (!c_ctl_r.q.origin_nz) begin
      push_found = 1'b0;
    end else if (c_ctl_r.q.ovr_valid) begin
      push_id  = c_ovr_id_r;
      push_src = SRC_OVERRIDE;
    end else if (ah_id_nxt != '0) begin
      push_id  = ah_id_nxt;
      push_src = SRC_DIRECTIONAL;
    end else if (c_ctl_r.q.wrap && (wr_id_nxt != '0)) begin
      push_id  = wr_id_nxt;
      push_src = SRC_WRAPPED;
    end else begin
      push_found = 1'b0;
    end
  end

endmodule

// ===== hw/rtl/dfs_outq.sv =====
module dfs_outq #(
  parameter int I = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  input  logic                                push_found,
  input  logic [I-1:0]                        push_id,
  input  dfs_pkg::src_t                       push_src,
  input  logic                                pop,
  output logic                                q_valid,
  output logic                                q_found,
  output logic [I-1:0]                        q_id,
  output dfs_pkg::src_t                       q_src,
  output logic [dfs_pkg::OQ_CNT_BITS-1:0]     q_count
);
  import dfs_pkg::*;

  localparam int EW = I + 3;

  logic [EW-1:0]          mem [OQ_DEPTH];
  logic [OQ_PTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [OQ_CNT_BITS-1:0] cnt_r;
  logic                   do_pop;

  assign do_pop = pop && (cnt_r != '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= {push_found, push_id, push_src};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + OQ_CNT_BITS'(push) - OQ_CNT_BITS'(do_pop);
    end
  end

  assign q_valid = (cnt_r != '0);
  assign q_count = cnt_r;
  assign q_found = mem[rd_ptr_r][EW-1];
  assign q_id    = mem[rd_ptr_r][EW-2:2];
  assign q_src   = src_t'(mem[rd_ptr_r][1:0]);

endmodule

// ===== hw/rtl/directional_focus_select.sv =====
// An item with tlast passes the input, geometry and score registers into the result queue.
// Throughput: one input item per cycle while in_tready is high; the score and best-compare
//   path is three register stages deep and an 8-entry result queue decouples the output side.
// in_tready drops only when queued results plus items in the pipeline fill that queue.
// Reset (rst_n low, synchronous): no query open, bests empty, queue empty,
//   sideways_weight back to 16 (1.0 in Q4.4).
module directional_focus_select #(
  parameter int COORD_BITS = 20,
  parameter int ID_BITS    = 16
) (
  input  logic clk,
  input  logic rst_n,
  // node_id, rect_x, rect_y, rect_w, rect_h, direction, wrap_around, override_id,
  // override_ok (lowest bit up), zero padded to bytes
  input  logic [((2*ID_BITS+4*COORD_BITS+2+7)/8)*8-1:0] in_tdata,
  input  logic in_tuser,   // opcode
  input  logic in_tlast,   // last
  input  logic in_tvalid,
  output logic in_tready,
  // found, target_id (lowest bit up), zero padded to bytes
  output logic [((ID_BITS+1+7)/8)*8-1:0] out_tdata,
  output logic [1:0] out_tuser,   // source
  output logic out_tvalid,
  input  logic out_tready,
  input  logic cfg_wr_en,
  input  logic [dfs_pkg::WEIGHT_BITS-1:0] cfg_wr_data
);
  import dfs_pkg::*;

  localparam int C        = COORD_BITS;
  localparam int I        = ID_BITS;
  localparam int OUT_DW   = ((I + 1 + 7) / 8) * 8;
  localparam int OFF_X    = I;
  localparam int OFF_Y    = I + C;
  localparam int OFF_W    = I + 2 * C;
  localparam int OFF_H    = I + 3 * C - 1;
  localparam int OFF_DIR  = I + 4 * C - 2;
  localparam int OFF_WRAP = OFF_DIR + 2;
  localparam int OFF_OVR  = OFF_WRAP + 1;
  localparam int OFF_OK   = OFF_OVR + I;

  logic [WEIGHT_BITS-1:0] weight_r;
  logic                   in_fire;
  logic                   a_valid;

  stg_ctl_t               b_ctl, c_ctl;
  logic [I-1:0]           b_id, b_ovr_id, c_id, c_ovr_id;
  logic [C-1:0]           b_fwd, b_gap;
  logic signed [C+1:0]    b_lo;
  logic [C+1:0]           b_ux, b_uy;
  logic signed [C+9:0]    c_sc, c_ws;
  logic [2*C+4:0]         c_dist;

  logic                   push, push_found;
  logic [I-1:0]           push_id;
  src_t                   push_src;
  logic                   q_found;
  logic [I-1:0]           q_id;
  src_t                   q_src;
  logic [OQ_CNT_BITS-1:0] q_count;
  logic [OQ_CNT_BITS-1:0] committed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r <= WEIGHT_RESET;
    end else if (cfg_wr_en) begin
      weight_r <= cfg_wr_data;
    end
  end

  // reserve a queue slot for every item still in the pipeline
  assign committed = q_count + OQ_CNT_BITS'(a_valid) + OQ_CNT_BITS'(b_ctl.valid) +
                     OQ_CNT_BITS'(c_ctl.valid);
  assign in_tready = (committed < OQ_CNT_BITS'(OQ_DEPTH));
  assign in_fire   = in_tvalid && in_tready;

  dfs_geom #(.C(C), .I(I)) u_geom (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_fire      (in_fire),
    .in_opcode    (in_tuser),
    .in_node_id   (in_tdata[I-1:0]),
    .in_rect_x    (in_tdata[OFF_X +: C]),
    .in_rect_y    (in_tdata[OFF_Y +: C]),
    .in_rect_w    (in_tdata[OFF_W +: C-1]),
    .in_rect_h    (in_tdata[OFF_H +: C-1]),
    .in_direction (dir_t'(in_tdata[OFF_DIR +: 2])),
    .in_wrap      (in_tdata[OFF_WRAP]),
    .in_ovr_id    (in_tdata[OFF_OVR +: I]),
    .in_ovr_ok    (in_tdata[OFF_OK]),
    .in_last      (in_tlast),
    .a_valid      (a_valid),
    .b_ctl_r      (b_ctl),
    .b_id_r       (b_id),
    .b_ovr_id_r   (b_ovr_id),
    .b_fwd_r      (b_fwd),
    .b_gap_r      (b_gap),
    .b_lo_r       (b_lo),
    .b_ux_r       (b_ux),
    .b_uy_r       (b_uy)
  );

  dfs_score #(.C(C), .I(I)) u_score (
    .clk        (clk),
    .rst_n      (rst_n),
    .weight     (weight_r),
    .b_ctl_r    (b_ctl),
    .b_id_r     (b_id),
    .b_ovr_id_r (b_ovr_id),
    .b_fwd_r    (b_fwd),
    .b_gap_r    (b_gap),
    .b_lo_r     (b_lo),
    .b_ux_r     (b_ux),
    .b_uy_r     (b_uy),
    .c_ctl_r    (c_ctl),
    .c_id_r     (c_id),
    .c_ovr_id_r (c_ovr_id),
    .c_sc_r     (c_sc),
    .c_ws_r     (c_ws),
    .c_dist_r   (c_dist)
  );

  dfs_best #(.C(C), .I(I)) u_best (
    .clk        (clk),
    .rst_n      (rst_n),
    .c_ctl_r    (c_ctl),
    .c_id_r     (c_id),
    .c_ovr_id_r (c_ovr_id),
    .c_sc_r     (c_sc),
    .c_ws_r     (c_ws),
    .c_dist_r   (c_dist),
    .push       (push),
    .push_found (push_found),
    .push_id    (push_id),
    .push_src   (push_src)
  );

  dfs_outq #(.I(I)) u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_found (push_found),
    .push_id    (push_id),
    .push_src   (push_src),
    .pop        (out_tready),
    .q_valid    (out_tvalid),
    .q_found    (q_found),
    .q_id       (q_id),
    .q_src      (q_src),
    .q_count    (q_count)
  );

  assign out_tdata = OUT_DW'({q_id, q_found});
  assign out_tuser = q_src;

endmodule

// ===== hw/rtl/dfs_chk.sv =====
module dfs_chk #(
  parameter int ID_BITS = 16
) (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 out_tvalid,
  input logic                                 out_tready,
  input logic [((ID_BITS+1+7)/8)*8-1:0]       out_tdata,
  input logic [1:0]                           out_tuser
);
  import dfs_pkg::*;

  // a stalled transfer keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // found is set exactly when a source is named
  a_found_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[0] == (out_tuser != SRC_NONE)))
    else $error("found and source disagree");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> (out_tdata[ID_BITS:1] == '0))
    else $error("target id nonzero with no target");

  a_found_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> (out_tdata[ID_BITS:1] != '0))
    else $error("target found with id zero");

  // reset empties the result queue
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

endmodule

bind directional_focus_select dfs_chk #(.ID_BITS(ID_BITS)) u_dfs_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== bench/dfs_checker.sv =====
module dfs_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [119:0] in_tdata,
  input  logic        in_tuser,
  input  logic        in_tlast,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] out_tdata,
  input  logic [1:0]  out_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_wr_en,
  input  logic [dfs_pkg::WEIGHT_BITS-1:0] cfg_wr_data,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import dfs_pkg::*;

  localparam longint          SCORE_CEIL = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint unsigned DIST_CEIL  = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct {
    longint x;
    longint y;
    longint w;
    longint h;
  } box_t;

  typedef struct packed {
    logic        found;
    logic [15:0] target_id;
    src_t        source;
  } focus_result_t;

  focus_result_t   target_q[$];

  logic [WEIGHT_BITS-1:0] weight;
  box_t            origin;
  logic [15:0]     origin_id;
  dir_t            q_dir;
  logic            q_wrap;
  logic [15:0]     q_ovr_id;
  logic            q_ovr_ok;
  logic            q_open;
  logic [15:0]     ahead_id;
  longint          ahead_score;
  longint unsigned ahead_dist;
  logic [15:0]     wrap_id;
  longint          wrap_score;
  longint unsigned wrap_dist;

  function automatic void clear_bests();
    ahead_id    = '0;
    ahead_score = SCORE_CEIL;
    ahead_dist  = DIST_CEIL;
    wrap_id     = '0;
    wrap_score  = SCORE_CEIL;
    wrap_dist   = DIST_CEIL;
  endfunction

  // travel axis, oriented so that ahead is larger
  function automatic void travel_span(input box_t b, input dir_t d,
                                      output longint lo, output longint hi);
    case (d)
      DIR_UP: begin
        lo = -(b.y + b.h);
        hi = -b.y;
      end
      DIR_DOWN: begin
        lo = b.y;
        hi = b.y + b.h;
      end
      DIR_LEFT: begin
        lo = -(b.x + b.w);
        hi = -b.x;
      end
      default: begin
        lo = b.x;
        hi = b.x + b.w;
      end
    endcase
  endfunction

  function automatic void cross_span(input box_t b, input dir_t d,
                                     output longint lo, output longint hi);
    if (d == DIR_UP || d == DIR_DOWN) begin
      lo = b.x;
      hi = b.x + b.w;
    end else begin
      lo = b.y;
      hi = b.y + b.h;
    end
  endfunction

  function automatic longint span_gap(input longint alo, input longint ahi,
                                      input longint blo, input longint bhi);
    longint g;
    g = 0;
    if (blo - ahi > g) g = blo - ahi;
    if (alo - bhi > g) g = alo - bhi;
    return g;
  endfunction

  function automatic bit predict_focus(input logic [119:0] d, input logic op,
                                       input logic last, output focus_result_t res);
    box_t            b;
    logic [15:0]     id;
    longint          oalo, oahi, oslo, oshi, calo, cahi, cslo, cshi;
    longint          side, dx, dy, fwd, sc, ws;
    longint unsigned ux, uy, cdist;
    res = '0;
    id  = d[15:0];
    b.x = longint'($signed(d[35:16]));
    b.y = longint'($signed(d[55:36]));
    b.w = longint'(d[74:56]);
    b.h = longint'(d[93:75]);
    if (op == OP_BEGIN) begin
      origin    = b;
      origin_id = id;
      q_dir     = dir_t'(d[95:94]);
      q_wrap    = d[96];
      q_ovr_id  = d[112:97];
      q_ovr_ok  = d[113];
      q_open    = 1'b1;
      clear_bests();
    end else begin
      if (!q_open) return 1'b0;
      if (id != '0 && id != origin_id) begin
        travel_span(origin, q_dir, oalo, oahi);
        cross_span(origin, q_dir, oslo, oshi);
        travel_span(b, q_dir, calo, cahi);
        cross_span(b, q_dir, cslo, cshi);
        side = longint'(weight) * span_gap(oslo, oshi, cslo, cshi);
        // doubled centres, no halving
        dx    = (2 * b.x + b.w) - (2 * origin.x + origin.w);
        dy    = (2 * b.y + b.h) - (2 * origin.y + origin.h);
        ux    = (dx < 0) ? -dx : dx;
        uy    = (dy < 0) ? -dy : dy;
        cdist = ux * ux + uy * uy;
        if (calo + cahi > oalo + oahi) begin
          fwd = calo - oahi;
          if (fwd < 0) fwd = 0;
          sc = 16 * fwd + side;
          if (sc < ahead_score || (sc == ahead_score && cdist < ahead_dist)) begin
            ahead_id    = id;
            ahead_score = sc;
            ahead_dist  = cdist;
          end
        end
        ws = 16 * calo + side;
        if (ws < wrap_score || (ws == wrap_score && cdist < wrap_dist)) begin
          wrap_id    = id;
          wrap_score = ws;
          wrap_dist  = cdist;
        end
      end
    end
    if (!last) return 1'b0;
    q_open     = 1'b0;
    res.source = SRC_NONE;
    if (origin_id == '0) begin
      res.source = SRC_NONE;
    end else if (q_ovr_ok && q_ovr_id != '0) begin
      res = '{found: 1'b1, target_id: q_ovr_id, source: SRC_OVERRIDE};
    end else if (ahead_id != '0) begin
      res = '{found: 1'b1, target_id: ahead_id, source: SRC_DIRECTIONAL};
    end else if (q_wrap && wrap_id != '0) begin
      res = '{found: 1'b1, target_id: wrap_id, source: SRC_WRAPPED};
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    focus_result_t got, want;
    if (!rst_n) begin
      weight    = WEIGHT_RESET;
      origin    = '{0, 0, 0, 0};
      origin_id = '0;
      q_dir     = DIR_UP;
      q_wrap    = 1'b0;
      q_ovr_id  = '0;
      q_ovr_ok  = 1'b0;
      q_open    = 1'b0;
      clear_bests();
      target_q.delete();
      fail_count = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (target_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result transfer: found=%0b id=%0d src=%0d",
                   $time, out_tdata[0], out_tdata[16:1], out_tuser);
        end else begin
          want = target_q.pop_front();
          if (out_tdata[0] !== want.found || out_tdata[16:1] !== want.target_id ||
              out_tuser !== want.source) begin
            fail_count++;
            $display("%0t: result mismatch: expected found=%0b id=%0d src=%0d, actual found=%0b id=%0d src=%0d",
                     $time, want.found, want.target_id, want.source,
                     out_tdata[0], out_tdata[16:1], out_tuser);
          end
        end
      end
      if (cfg_wr_en) weight = cfg_wr_data;
      if (in_tvalid && in_tready) begin
        if (predict_focus(in_tdata, in_tuser, in_tlast, got)) begin
          target_q.insert(target_q.size(), got);
        end
      end
    end
    pending = target_q.size();
  end

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dfs_pkg::*;

  localparam int COORD_BITS     = 20;
  localparam int ID_BITS        = 16;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int PHASE_ITEMS    = 210;

  localparam logic signed [19:0] C_MIN = 20'sh80000;
  localparam logic signed [19:0] C_MAX = 20'sh7FFFF;
  localparam logic [18:0]        S_MAX = 19'h7FFFF;

  logic         clk;
  logic         rst_n;
  logic [119:0] in_tdata;    // node_id, rect_x, rect_y, rect_w, rect_h, direction,
                             // wrap_around, override_id, override_ok, zero pad
  logic         in_tuser;    // opcode
  logic         in_tlast;    // last
  logic         in_tvalid;
  logic         in_tready;
  logic [23:0]  out_tdata;   // found, target_id, zero pad
  logic [1:0]   out_tuser;   // source
  logic         out_tvalid;
  logic         out_tready = 1'b1;
  logic         cfg_wr_en;
  logic [WEIGHT_BITS-1:0] cfg_wr_data;

  int fail_count;
  int pending;
  int items_sent = 0;
  int out_stall  = 0;
  int stuck_cycles = 0;
  bit idle_on = 1'b1;

  directional_focus_select #(
    .COORD_BITS(COORD_BITS),
    .ID_BITS   (ID_BITS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  dfs_checker focus_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver stalls in random bursts while idle_on is set
  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_stall--;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      out_stall = $urandom_range(0, 16);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic send_item(input logic op, input logic [15:0] id,
                           input logic signed [19:0] x, input logic signed [19:0] y,
                           input logic [18:0] w, input logic [18:0] h, input dir_t d,
                           input logic wrap, input logic [15:0] oid, input logic ook,
                           input logic last);
    int gap;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 17);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tlast  <= last;
    in_tdata  <= {6'b0, ook, oid, wrap, d, h, w, y, x, id};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // drop valid and wait until every result is out and the pipeline is empty
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_weight(input logic [WEIGHT_BITS-1:0] w);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= w;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // scale 0 packs rects tightly for ties, 2 spans the full coordinate range
  task automatic gen_rect(input int scale, output logic signed [19:0] x,
                          output logic signed [19:0] y, output logic [18:0] w,
                          output logic [18:0] h);
    case (scale)
      0: begin
        x = 20'(int'($urandom_range(0, 127)) - 64);
        y = 20'(int'($urandom_range(0, 127)) - 64);
        w = 19'($urandom_range(0, 32));
        h = 19'($urandom_range(0, 32));
      end
      1: begin
        x = 20'(int'($urandom_range(0, 4095)) - 2048);
        y = 20'(int'($urandom_range(0, 4095)) - 2048);
        w = 19'($urandom_range(0, 511));
        h = 19'($urandom_range(0, 511));
      end
      default: begin
        x = 20'($urandom());
        y = 20'($urandom());
        w = 19'($urandom());
        h = 19'($urandom());
      end
    endcase
  endtask

  task automatic run_query(input bit noise_ok);
    int                 kind, ncand, scale, pick;
    bit                 aborted;
    logic [15:0]        origin_id, ovr, cid;
    logic               ook, wrap;
    dir_t               d;
    logic signed [19:0] ox, oy, cx, cy;
    logic [18:0]        ow, oh, cw, ch;
    kind  = noise_ok ? $urandom_range(0, 19) : 2;
    pick  = $urandom_range(0, 3);
    scale = (pick == 3) ? 2 : (pick == 0) ? 0 : 1;
    if (kind == 0) begin
      // stray candidates, sent with no begin item of their own
      repeat ($urandom_range(1, 3)) begin
        gen_rect(scale, cx, cy, cw, ch);
        send_item(OP_CAND, 16'($urandom()), cx, cy, cw, ch, dir_t'($urandom_range(0, 3)),
                  1'($urandom()), 16'($urandom()), 1'($urandom()), 1'($urandom()));
      end
      return;
    end
    origin_id = ($urandom_range(0, 15) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
    ovr       = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom());
    ook       = ($urandom_range(0, 3) == 0);
    wrap      = 1'($urandom_range(0, 1));
    d         = dir_t'($urandom_range(0, 3));
    ncand     = $urandom_range(0, 12);
    aborted   = (kind == 1) && (ncand > 0);
    gen_rect(scale, ox, oy, ow, oh);
    send_item(OP_BEGIN, origin_id, ox, oy, ow, oh, d, wrap, ovr, ook, ncand == 0);
    items_sent++;
    cx = ox;
    cy = oy;
    cw = ow;
    ch = oh;
    for (int i = 0; i < ncand; i++) begin
      pick = $urandom_range(0, 15);
      if (pick == 0) cid = 16'd0;
      else if (pick == 1) cid = origin_id;
      else cid = 16'($urandom_range(1, 65535));
      // pick 2 repeats the previous rect to force ties
      if (pick == 3) begin
        cx = ox;
        cy = oy;
        cw = ow;
        ch = oh;
      end else if (pick != 2 || i == 0) begin
        gen_rect(scale, cx, cy, cw, ch);
      end
      send_item(OP_CAND, cid, cx, cy, cw, ch, dir_t'($urandom_range(0, 3)),
                1'($urandom()), 16'($urandom()), 1'($urandom()),
                (i == ncand - 1) && !aborted);
      items_sent++;
    end
  endtask

  initial begin
    logic [WEIGHT_BITS-1:0] weights [7];
    int target;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = 1'b0;
    in_tlast    = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // candidates with no open query
    send_item(OP_CAND, 16'd3, 20'sd0, 20'sd0, 19'd16, 19'd16, DIR_UP, 1'b0, 16'd0, 1'b0, 1'b0);
    send_item(OP_CAND, 16'd4, 20'sd8, 20'sd8, 19'd16, 19'd16, DIR_UP, 1'b0, 16'd0, 1'b0, 1'b1);
    // origin id zero
    send_item(OP_BEGIN, 16'd0, 20'sd0, 20'sd0, 19'd16, 19'd16, DIR_DOWN, 1'b1, 16'd9, 1'b1, 1'b1);
    // override wins, begin with last
    send_item(OP_BEGIN, 16'd5, 20'sd0, 20'sd0, 19'd16, 19'd16, DIR_LEFT, 1'b0, 16'hFFFF, 1'b1,
              1'b1);
    // directional, with a zero id and the origin id ignored
    send_item(OP_BEGIN, 16'd5, 20'sd0, 20'sd0, 19'd16, 19'd16, DIR_RIGHT, 1'b0, 16'd9, 1'b0,
              1'b0);
    send_item(OP_CAND, 16'd3, 20'sd100, 20'sd0, 19'd16, 19'd16, DIR_UP, 1'b0, 16'd0, 1'b0, 1'b0);
    send_item(OP_CAND, 16'd0, 20'sd50, 20'sd0, 19'd16, 19'd16, DIR_UP, 1'b0, 16'd0, 1'b0, 1'b0);
    send_item(OP_CAND, 16'd5, 20'sd40, 20'sd0, 19'd16, 19'd16, DIR_UP, 1'b0, 16'd0, 1'b0, 1'b1);
    // nothing ahead: wrapped, then none without wrap
    send_item(OP_BEGIN, 16'd1, 20'sd0, 20'sd0, 19'd16, 19'd16, DIR_UP, 1'b1, 16'd0, 1'b1, 1'b0);
    send_item(OP_CAND, 16'd2, 20'sd0, 20'sd100, 19'd16, 19'd16, DIR_UP, 1'b0, 16'd0, 1'b0, 1'b0);
    send_item(OP_CAND, 16'd3, 20'sd0, 20'sd200, 19'd16, 19'd16, DIR_UP, 1'b0, 16'd0, 1'b0, 1'b1);
    send_item(OP_BEGIN, 16'd1, 20'sd0, 20'sd0, 19'd16, 19'd16, DIR_UP, 1'b0, 16'd0, 1'b0, 1'b0);
    send_item(OP_CAND, 16'd2, 20'sd0, 20'sd100, 19'd16, 19'd16, DIR_UP, 1'b0, 16'd0, 1'b0, 1'b1);
    // begin drops the open query; coordinate extremes
    send_item(OP_BEGIN, 16'd7, 20'sd0, 20'sd0, 19'd16, 19'd16, DIR_LEFT, 1'b1, 16'd0, 1'b0, 1'b0);
    send_item(OP_CAND, 16'd9, -20'sd200, 20'sd0, 19'd16, 19'd16, DIR_UP, 1'b0, 16'd0, 1'b0, 1'b0);
    send_item(OP_BEGIN, 16'd8, C_MIN, C_MIN, S_MAX, S_MAX, DIR_DOWN, 1'b1, 16'hFFFF, 1'b0, 1'b0);
    send_item(OP_CAND, 16'hFFFF, C_MAX, C_MAX, S_MAX, S_MAX, DIR_UP, 1'b0, 16'd0, 1'b0, 1'b0);
    send_item(OP_CAND, 16'd4, C_MIN, C_MIN, 19'd0, 19'd0, DIR_UP, 1'b0, 16'd0, 1'b0, 1'b0);
    send_item(OP_CAND, 16'd6, 20'sd0, 20'sd1000, 19'd16, 19'd16, DIR_UP, 1'b0, 16'd0, 1'b0, 1'b1);
    // identical candidates: the earlier one holds
    send_item(OP_BEGIN, 16'hFFFF, 20'sd0, 20'sd0, 19'd16, 19'd16, DIR_DOWN, 1'b1, 16'd0, 1'b1,
              1'b0);
    send_item(OP_CAND, 16'd10, 20'sd0, 20'sd100, 19'd16, 19'd16, DIR_UP, 1'b0, 16'd0, 1'b0, 1'b0);
    send_item(OP_CAND, 16'd11, 20'sd0, 20'sd100, 19'd16, 19'd16, DIR_UP, 1'b0, 16'd0, 1'b0, 1'b1);
    // still at the reset weight
    target = items_sent + PHASE_ITEMS / 2;
    while (items_sent < target) run_query(1'b1);
    run_query(1'b0);

    weights = '{8'd255, 8'd0, 8'($urandom()), 8'd1, 8'd16, 8'($urandom()), 8'd128};
    for (int p = 0; p < 7; p++) begin
      settle();
      write_weight(weights[p]);
      if (p == 6) idle_on = 1'b0;
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target - PHASE_ITEMS / 2) run_query(1'b1);
      // hold the sender until the result queue has drained
      settle();
      while (items_sent < target) run_query(1'b1);
      run_query(1'b0);
    end

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== directional_focus_select.f =====
hw/rtl/dfs_pkg.sv
hw/rtl/dfs_geom.sv
hw/rtl/dfs_score.sv
hw/rtl/dfs_best.sv
hw/rtl/dfs_outq.sv
hw/rtl/directional_focus_select.sv
hw/rtl/dfs_chk.sv
bench/dfs_checker.sv
bench/tb_top.sv
